>>> hdl/z_morton_block_matrix_multiply_top_macros.svh
// Assertion macros for the Z-Morton block matrix multiply top level
`ifndef Z_MORTON_BLOCK_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define Z_MORTON_BLOCK_MATRIX_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, clocked by clock and disabled in reset
`define ZMBMM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked by clock and disabled in reset
`define ZMBMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/zmbmm_pkg.sv
// Shared types, opcodes and elaboration helpers for the Z-Morton matrix multiply
`timescale 1ns / 1ps
`default_nettype none

package zmbmm_pkg;

   localparam int INDEX_W = 8;
   localparam int VALUE_W = 32;

   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [2:0]                opcode_type;

   localparam opcode_type OP_LOAD_A  = 3'd0;
   localparam opcode_type OP_LOAD_B  = 3'd1;
   localparam opcode_type OP_CLEAR_C = 3'd2;
   localparam opcode_type OP_MAC     = 3'd3;
   localparam opcode_type OP_READ_C  = 3'd4;

   // decoded word for the datapath (loads and C reads)
   typedef struct packed {
      logic      load_a;
      logic      load_b;
      logic      read_c;
      logic      in_range;
      index_type index;
      value_type value;
   } req_cmd_type;

   // commands that start a controller sequence
   typedef struct packed {
      logic mac;
      logic clear;
   } start_type;

   // one issue slot from the controller
   typedef struct packed {
      logic valid;  // MAC operand fetch
      logic first;  // first k step of a C element
      logic last;   // last k step, write back
      logic clear;  // zero one C entry
   } mac_cmd_type;

   // datapath status back to controller and top
   typedef struct packed {
      logic pipe_busy;
      logic rd_pend;
      logic can_accept;
   } dp_status_type;

   // number of quadrant splits before a block fits a tile
   function automatic int calc_levels(int n, int t);
      int lv;
      int m;
      lv = 0;
      m  = n;
      while (m > t && m >= 2) begin
         m  = m >> 1;
         lv = lv + 1;
      end
      return lv;
   endfunction

   // quadrant of C, A and B for each of the eight sub-products of a block
   function automatic logic [1:0] quad_c(logic [2:0] d);
      return d[2:1];
   endfunction

   function automatic logic [1:0] quad_a(logic [2:0] d);
      return {d[2], d[0]};
   endfunction

   function automatic logic [1:0] quad_b(logic [2:0] d);
      return {d[0], d[1]};
   endfunction

endpackage

`default_nettype wire

>>> hdl/zmbmm_ifs.sv
// Request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface zmbmm_req_if import zmbmm_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   index_type  element_index;
   value_type  element_value;

   modport source (output valid, output opcode, output element_index,
                   output element_value, input ready);
   modport sink   (input valid, input opcode, input element_index,
                   input element_value, output ready);
endinterface

interface zmbmm_rsp_if import zmbmm_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type result_value;
   index_type result_index;

   modport source (output valid, output result_value, output result_index,
                   input ready);
   modport sink   (input valid, input result_value, input result_index,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/zmbmm_ctrl.sv
// Controller: clear sweep and recursive Z-Morton MAC sequencing with address generation
`timescale 1ns / 1ps
`default_nettype none

module zmbmm_ctrl import zmbmm_pkg::*; #(
   parameter int MATRIX_SIZE = 16,
   parameter int TILE_SIZE   = 4,
   localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE,
   localparam int AW         = $clog2(ELEM_COUNT)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire start_type     start,
   input  wire dp_status_type status,
   output logic               idle,
   output mac_cmd_type        cmd,
   output logic [AW-1:0]      a_addr,
   output logic [AW-1:0]      b_addr,
   output logic [AW-1:0]      c_addr
);

   localparam int LEVELS    = calc_levels(MATRIX_SIZE, TILE_SIZE);
   localparam int NL        = MATRIX_SIZE >> LEVELS;
   localparam int KW        = (NL > 1) ? $clog2(NL) : 1;
   localparam int LW        = (LEVELS > 0) ? 3 * LEVELS : 1;
   localparam int LEAF_LAST = (1 << (3 * LEVELS)) - 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_MAC   = 4'b0100,
      ST_DRAIN = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   mac_cmd_type    cmd_ff, cmd_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [LW-1:0]  leaf_ff, leaf_in;
   logic [KW-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0]  a_off_ff, a_off_in, b_off_ff, b_off_in, c_off_ff, c_off_in;
   logic [AW-1:0]  a_addr_ff, a_addr_in, b_addr_ff, b_addr_in, c_addr_ff, c_addr_in;
   logic [AW-1:0]  i_row, j_row;
   logic           k_last, j_last, i_last, leaf_last, clr_last;

   assign k_last    = (k_ff == KW'(NL - 1));
   assign j_last    = (j_ff == KW'(NL - 1));
   assign i_last    = (i_ff == KW'(NL - 1));
   assign leaf_last = (leaf_ff == LW'(LEAF_LAST));
   assign clr_last  = (clr_ff == AW'(ELEM_COUNT - 1));

   // row bases inside the current tile
   assign i_row = AW'(AW'(i_ff) * AW'(NL));
   assign j_row = AW'(AW'(j_ff) * AW'(NL));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = '0;
      clr_in    = clr_ff;
      leaf_in   = leaf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      a_addr_in = a_off_ff + i_row + AW'(k_ff);
      b_addr_in = b_off_ff + j_row + AW'(k_ff);
      c_addr_in = c_off_ff + i_row + AW'(j_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start.clear) begin
               state_in = ST_CLEAR;
               clr_in   = '0;
            end else if (start.mac) begin
               state_in = ST_MAC;
               leaf_in  = '0;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_CLEAR: begin
            cmd_in.clear = 1'b1;
            c_addr_in    = clr_ff;
            if (clr_last) begin
               state_in = ST_DRAIN;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_MAC: begin
            cmd_in.valid = 1'b1;
            cmd_in.first = (k_ff == '0);
            cmd_in.last  = k_last;
            k_in         = k_last ? '0 : k_ff + KW'(1);
            if (k_last) begin
               j_in = j_last ? '0 : j_ff + KW'(1);
            end
            if (k_last && j_last) begin
               i_in = i_last ? '0 : i_ff + KW'(1);
            end
            if (k_last && j_last && i_last) begin
               leaf_in = leaf_ff + LW'(1);
               if (leaf_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!cmd_ff.valid && !cmd_ff.clear && !status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // tile offsets of the next leaf: one quadrant term per recursion level
   always_comb begin
      a_off_in = '0;
      b_off_in = '0;
      c_off_in = '0;
      for (int l = 0; l < LEVELS; l++) begin
         a_off_in = a_off_in + AW'(AW'(quad_a(leaf_in[3*(LEVELS-1-l) +: 3]))
                    * AW'((MATRIX_SIZE >> (l + 1)) * (MATRIX_SIZE >> (l + 1))));
         b_off_in = b_off_in + AW'(AW'(quad_b(leaf_in[3*(LEVELS-1-l) +: 3]))
                    * AW'((MATRIX_SIZE >> (l + 1)) * (MATRIX_SIZE >> (l + 1))));
         c_off_in = c_off_in + AW'(AW'(quad_c(leaf_in[3*(LEVELS-1-l) +: 3]))
                    * AW'((MATRIX_SIZE >> (l + 1)) * (MATRIX_SIZE >> (l + 1))));
      end
   end

   // control state; reset starts the C clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cmd_ff   <= '0;
         clr_ff   <= '0;
         leaf_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
         clr_ff   <= clr_in;
         leaf_ff  <= leaf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // address registers
   always_ff @(posedge clock) begin
      a_off_ff  <= a_off_in;
      b_off_ff  <= b_off_in;
      c_off_ff  <= c_off_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      c_addr_ff <= c_addr_in;
   end

   assign idle   = (state_ff == ST_IDLE);
   assign cmd    = cmd_ff;
   assign a_addr = a_addr_ff;
   assign b_addr = b_addr_ff;
   assign c_addr = c_addr_ff;

endmodule

`default_nettype wire

>>> hdl/zmbmm_dp.sv
// Datapath: A, B and C memories, MAC pipeline and response register
`timescale 1ns / 1ps
`default_nettype none

module zmbmm_dp import zmbmm_pkg::*; #(
   parameter int MATRIX_SIZE = 16,
   localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE,
   localparam int AW         = $clog2(ELEM_COUNT)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_cmd_type  req_cmd,
   input  wire mac_cmd_type  cmd,
   input  wire logic [AW-1:0] a_addr,
   input  wire logic [AW-1:0] b_addr,
   input  wire logic [AW-1:0] c_addr,
   output dp_status_type     status,
   zmbmm_rsp_if.source       rsp_chan
);

   logic [VALUE_W-1:0] mem_a [ELEM_COUNT];
   logic [VALUE_W-1:0] mem_b [ELEM_COUNT];
   logic [VALUE_W-1:0] mem_c [ELEM_COUNT];

   logic [AW-1:0]      req_addr;
   logic [VALUE_W-1:0] a_q_ff, b_q_ff, c_q_ff, prod_ff, acc_ff, acc_in;
   logic [VALUE_W-1:0] prod_full;
   logic               v1_ff, v2_ff, first1_ff, first2_ff, last1_ff, last2_ff;
   logic [AW-1:0]      c_addr1_ff, c_addr2_ff;
   logic               wb_en, bypass;

   logic [VALUE_W-1:0] rd_data_ff;
   index_type          rd_index_ff;
   logic               rd_inside_ff, pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in, move;
   value_type          rsp_value_ff;
   index_type          rsp_index_ff;

   assign req_addr = AW'(req_cmd.index);

   // A store: load write, MAC operand read
   always_ff @(posedge clock) begin
      if (req_cmd.load_a) begin
         mem_a[req_addr] <= req_cmd.value;
      end
      if (cmd.valid) begin
         a_q_ff <= mem_a[a_addr];
      end
   end

   // B store
   always_ff @(posedge clock) begin
      if (req_cmd.load_b) begin
         mem_b[req_addr] <= req_cmd.value;
      end
      if (cmd.valid) begin
         b_q_ff <= mem_b[b_addr];
      end
   end

   // stage 2: product (low word); stage 3: accumulate, seeded with the old C entry
   assign prod_full = a_q_ff * b_q_ff;
   assign acc_in    = (first2_ff ? c_q_ff : acc_ff) + prod_ff;
   assign wb_en     = v2_ff && last2_ff;
   assign bypass    = wb_en && (c_addr2_ff == c_addr1_ff);

   always_ff @(posedge clock) begin
      first1_ff  <= cmd.first;
      last1_ff   <= cmd.last;
      c_addr1_ff <= c_addr;
      first2_ff  <= first1_ff;
      last2_ff   <= last1_ff;
      c_addr2_ff <= c_addr1_ff;
      prod_ff    <= prod_full;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // C store: clear sweep or write back, MAC read with write forwarding, response read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem_c[c_addr] <= '0;
      end else if (wb_en) begin
         mem_c[c_addr2_ff] <= acc_in;
      end
      if (v1_ff) begin
         c_q_ff <= bypass ? acc_in : mem_c[c_addr1_ff];
      end
      if (req_cmd.read_c) begin
         rd_data_ff   <= mem_c[req_addr];
         rd_index_ff  <= req_cmd.index;
         rd_inside_ff <= req_cmd.in_range;
      end
   end

   // response hand-off: a read word waits in the pending slot until the output frees
   assign move         = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign pend_in      = req_cmd.read_c || (pend_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_value_ff <= rd_inside_ff ? rd_data_ff : '0;
         rsp_index_ff <= rd_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= cmd.valid;
         v2_ff        <= v1_ff;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.pipe_busy  = v1_ff || v2_ff;
   assign status.rd_pend    = pend_ff;
   assign status.can_accept = !pend_ff || !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.result_index = rsp_index_ff;

endmodule

`default_nettype wire

>>> hdl/z_morton_block_matrix_multiply_top.sv
// Loads and reads: accepted every cycle while the controller is idle and the response
// path can take a word; a read word moves from the pending slot to the output register.
// Multiply-accumulate: 8^L leaf tile products for L quadrant splits, one MAC per cycle
// through one multiplier, then a drain. Clear C: MATRIX_SIZE^2 entries, one a cycle.
// Reset (synchronous) runs the same C clear sweep; no word is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "z_morton_block_matrix_multiply_top_macros.svh"

module z_morton_block_matrix_multiply_top import zmbmm_pkg::*; #(
   parameter int MATRIX_SIZE = 16,
   parameter int TILE_SIZE   = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   zmbmm_req_if.sink   req_chan,
   zmbmm_rsp_if.source rsp_chan
);

   localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE;
   localparam int AW         = $clog2(ELEM_COUNT);

   logic          accept, in_range, ctrl_idle, rd_move;
   req_cmd_type   req_cmd;
   start_type     start;
   mac_cmd_type   cmd;
   dp_status_type dp_status;
   logic [AW-1:0] a_addr, b_addr, c_addr;

   // request decode
   assign req_chan.ready = ctrl_idle && dp_status.can_accept;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_range       = (32'(req_chan.element_index) < 32'(ELEM_COUNT));

   assign req_cmd.load_a   = accept && (req_chan.opcode == OP_LOAD_A) && in_range;
   assign req_cmd.load_b   = accept && (req_chan.opcode == OP_LOAD_B) && in_range;
   assign req_cmd.read_c   = accept && (req_chan.opcode == OP_READ_C);
   assign req_cmd.in_range = in_range;
   assign req_cmd.index    = req_chan.element_index;
   assign req_cmd.value    = req_chan.element_value;

   assign start.mac   = accept && (req_chan.opcode == OP_MAC);
   assign start.clear = accept && (req_chan.opcode == OP_CLEAR_C);

   zmbmm_ctrl #(
      .MATRIX_SIZE(MATRIX_SIZE),
      .TILE_SIZE  (TILE_SIZE)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(dp_status),
      .idle  (ctrl_idle),
      .cmd   (cmd),
      .a_addr(a_addr),
      .b_addr(b_addr),
      .c_addr(c_addr)
   );

   zmbmm_dp #(
      .MATRIX_SIZE(MATRIX_SIZE)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_cmd (req_cmd),
      .cmd     (cmd),
      .a_addr  (a_addr),
      .b_addr  (b_addr),
      .c_addr  (c_addr),
      .status  (dp_status),
      .rsp_chan(rsp_chan)
   );

   // pending read word moves to the output this cycle
   assign rd_move = dp_status.rd_pend && (!rsp_chan.valid || rsp_chan.ready);

   // checks
   `ZMBMM_ASSERT_IMPL(a_busy_not_idle, dp_status.pipe_busy, !ctrl_idle, "MAC busy while idle")
   `ZMBMM_ASSERT_NEXT(a_mac_leaves_idle, start.mac, !ctrl_idle, "MAC start did not leave idle")
   `ZMBMM_ASSERT_NEXT(a_read_goes_pending, req_cmd.read_c, dp_status.rd_pend, "read not pending")
   `ZMBMM_ASSERT_NEXT(a_pending_reaches_out, rd_move, rsp_chan.valid, "read word lost")

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the Z-Morton block matrix multiply top level
`timescale 1ns / 1ps

module tb import zmbmm_pkg::*; ();

   localparam int MATRIX_SIZE = 16;
   localparam int TILE_SIZE   = 4;
   localparam int ELEM_COUNT  = MATRIX_SIZE * MATRIX_SIZE;

   // opcodes the block decodes as no-ops
   localparam opcode_type OP_SPARE_5 = 3'd5;
   localparam opcode_type OP_SPARE_6 = 3'd6;
   localparam opcode_type OP_SPARE_7 = 3'd7;

   localparam int READ_LATENCY = 2;
   localparam int MAC_CYCLES   = 4100;
   localparam longint TIMEOUT_NS = 64'd4_000_000;

   typedef struct {
      value_type value;
      index_type index;
   } c_read_type;

   logic clock;
   logic reset;

   zmbmm_req_if req_chan ();
   zmbmm_rsp_if rsp_chan ();

   z_morton_block_matrix_multiply_top #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .TILE_SIZE   (TILE_SIZE)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copies of the three matrices, in layout order
   value_type a_mem [ELEM_COUNT];
   value_type b_mem [ELEM_COUNT];
   value_type c_mem [ELEM_COUNT];

   c_read_type pending_reads [$];
   int         error_count;
   int         send_gap_pct;
   int         rsp_stall_pct;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

   // layout index of element (row, col); quadrants 11,12,21,22 nest down to a tile,
   // tiles are row-major, or column-major for B. Exact for power-of-two splits.
   function automatic int morton_offset(int row, int col, bit col_major);
      int n;
      int half;
      int base;
      n    = MATRIX_SIZE;
      base = 0;
      while (n > TILE_SIZE && n >= 2) begin
         half = n >> 1;
         base = base + ((row >= half ? 2 : 0) + (col >= half ? 1 : 0)) * half * half;
         if (row >= half) row = row - half;
         if (col >= half) col = col - half;
         n = half;
      end
      return col_major ? base + col * n + row : base + row * n + col;
   endfunction

   // C += A * B, wrapping at 32 bits; summation order is irrelevant mod 2^32
   task automatic accumulate_product();
      value_type sum;
      for (int i = 0; i < MATRIX_SIZE; i++) begin
         for (int j = 0; j < MATRIX_SIZE; j++) begin
            sum = '0;
            for (int k = 0; k < MATRIX_SIZE; k++)
               sum = sum + a_mem[morton_offset(i, k, 1'b0)] * b_mem[morton_offset(k, j, 1'b1)];
            c_mem[morton_offset(i, j, 1'b0)] += sum;
         end
      end
   endtask

   // apply one accepted word to the shadow matrices
   task automatic update_matrices(opcode_type op, index_type idx, value_type val);
      bit         in_range;
      c_read_type rd_word;
      in_range = int'(idx) < ELEM_COUNT;
      case (op)
         OP_LOAD_A: begin
            if (in_range) a_mem[idx] = val;
         end
         OP_LOAD_B: begin
            if (in_range) b_mem[idx] = val;
         end
         OP_CLEAR_C: begin
            foreach (c_mem[i]) c_mem[i] = '0;
         end
         OP_MAC: begin
            accumulate_product();
         end
         OP_READ_C: begin
            rd_word.value = in_range ? c_mem[idx] : value_type'(0);
            rd_word.index = idx;
            pending_reads.insert(pending_reads.size(), rd_word);
         end
         default: begin
         end
      endcase
   endtask

   // response check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      c_read_type exp_rd;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_reads.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word: expected none, actual value %h index %0d",
                        $time, rsp_chan.result_value, rsp_chan.result_index);
            end else begin
               exp_rd = pending_reads.pop_front();
               if (rsp_chan.result_value !== exp_rd.value ||
                   rsp_chan.result_index !== exp_rd.index) begin
                  error_count++;
                  $display("%0t: mismatch: expected value %h index %0d, actual value %h index %0d",
                           $time, exp_rd.value, exp_rd.index,
                           rsp_chan.result_value, rsp_chan.result_index);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            update_matrices(req_chan.opcode, req_chan.element_index, req_chan.element_value);
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_chan.ready = !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // operand values, extremes now and then
   function automatic value_type pick_value();
      case ($urandom_range(15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '1;
         3:       return '0;
         default: return value_type'($urandom);
      endcase
   endfunction

   // drive one word, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_word(opcode_type op, index_type idx, value_type val);
      if ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_chan.valid         = 1'b1;
      req_chan.opcode        = op;
      req_chan.element_index = idx;
      req_chan.element_value = val;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // hold off the sender until every read word is back
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (READ_LATENCY + 2) @(negedge clock);
   endtask

   // C is zero out of reset
   task automatic test_reset_state();
      send_word(OP_READ_C, 8'd0, '0);
      send_word(OP_READ_C, 8'd255, '1);
      send_word(OP_READ_C, 8'd128, '0);
   endtask

   // every A and B entry is written before any multiply
   task automatic test_fill_operands();
      for (int i = 0; i < ELEM_COUNT; i++) begin
         send_word(OP_LOAD_A, index_type'(i), pick_value());
         send_word(OP_LOAD_B, index_type'(i), pick_value());
      end
   endtask

   // wraparound of products and sums at the value extremes
   task automatic test_extreme_operands();
      send_word(OP_LOAD_A, 8'd0, 32'sh8000_0000);
      send_word(OP_LOAD_B, 8'd0, 32'sh8000_0000);
      send_word(OP_LOAD_A, 8'd255, 32'sh7fff_ffff);
      send_word(OP_LOAD_B, 8'd255, '1);
      send_word(OP_LOAD_A, 8'd1, '1);
      send_word(OP_LOAD_B, 8'd1, 32'sh7fff_ffff);
      send_word(OP_MAC, 8'd0, '0);
      send_word(OP_READ_C, 8'd0, '0);
      send_word(OP_READ_C, 8'd1, '0);
      send_word(OP_READ_C, 8'd16, '0);
      send_word(OP_READ_C, 8'd255, '0);
   endtask

   // clear, and the spare opcodes leave everything alone
   task automatic test_clear_and_spares();
      send_word(OP_SPARE_5, 8'd255, '1);
      send_word(OP_SPARE_6, 8'd0, 32'sh7fff_ffff);
      send_word(OP_SPARE_7, 8'd170, 32'sh8000_0000);
      send_word(OP_READ_C, 8'd0, '0);
      send_word(OP_CLEAR_C, 8'd85, '1);
      send_word(OP_READ_C, 8'd0, '0);
      send_word(OP_READ_C, 8'd255, '0);
      send_word(OP_MAC, 8'd255, '1);
      send_word(OP_READ_C, 8'd255, '0);
   endtask

   // mostly load / multiply / read-back sequences, some random noise
   task automatic test_random_traffic(int n_words);
      int         sent;
      int         burst;
      opcode_type op;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(99) < 80) begin
            burst = $urandom_range(12);
            repeat (burst)
               send_word($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
                         index_type'($urandom_range(255)), pick_value());
            sent += burst;
            if ($urandom_range(99) < 5) begin
               send_word(OP_CLEAR_C, index_type'($urandom), value_type'($urandom));
               sent++;
            end
            if ($urandom_range(99) < 35) begin
               send_word(OP_MAC, index_type'($urandom), value_type'($urandom));
               sent++;
            end
            burst = $urandom_range(1, 10);
            repeat (burst)
               send_word(OP_READ_C, index_type'($urandom_range(255)), value_type'($urandom));
            sent += burst;
         end else begin
            // any opcode, any fields
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               op = opcode_type'($urandom_range(7));
               send_word(op, index_type'($urandom), pick_value());
               if (op != OP_SPARE_5 && op != OP_SPARE_6 && op != OP_SPARE_7) sent++;
            end
         end
      end
   endtask

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_READ_C;
      req_chan.element_index = '0;
      req_chan.element_value = '0;
      error_count            = 0;
      send_gap_pct           = 10;
      rsp_stall_pct          = 81;
      foreach (a_mem[i]) a_mem[i] = '0;
      foreach (b_mem[i]) b_mem[i] = '0;
      foreach (c_mem[i]) c_mem[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // phase 1: light sender gaps, heavy receiver stalls
      test_reset_state();
      test_fill_operands();
      test_extreme_operands();
      test_clear_and_spares();
      test_random_traffic(300);
      wait_drained();

      // phase 2: heavy sender gaps, light receiver stalls
      send_gap_pct  = 81;
      rsp_stall_pct = 10;
      test_random_traffic(300);
      wait_drained();

      // phase 3: full rate both ways
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      test_random_traffic(300);
      wait_drained();

      // let a trailing multiply finish and catch any stray word
      repeat (MAC_CYCLES + 16) @(negedge clock);
      if (error_count == 0 && pending_reads.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
